### src/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types, constants and helpers for the probe packet checker.
// ----------------------------------------------------------------------------
package ppc_pkg;

   // Sizing of the received-sequence map and of the packet length range
   localparam int MAX_SEQUENCES    = 1024;
   localparam int MAX_PACKET_BYTES = 2048;
   localparam int SEQ_IDX_W        = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
   localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 2);

   // Field and register widths
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 32;
   localparam int PHASE_W  = 32;
   localparam int TOTAL_W  = 11;
   localparam int LENGTH_W = 12;

   // Header layout and payload pattern
   localparam logic [WORD_W-1:0] MARKER_WORD  = 32'h4c4e5855;
   localparam logic [BYTE_W-1:0] PHASE_WEIGHT = 8'd17;
   localparam logic [BYTE_W-1:0] PATTERN_STEP = 8'd31;
   localparam int                HEADER_BYTES = 16;
   localparam logic [BYTE_W-1:0] PATTERN_SEED = 8'((HEADER_BYTES * 31) % 256);

   localparam int PHASE_START = 4;
   localparam int SEQ_START   = 8;
   localparam int TOTAL_START = 12;

   // Register reset values
   localparam logic [PHASE_W-1:0]  PHASE_RESET  = 32'd2;
   localparam logic [TOTAL_W-1:0]  TOTAL_RESET  = 11'd1000;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 12'd1200;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EXPECTED_PHASE = 2'd0,
      CSR_EXPECTED_TOTAL = 2'd1,
      CSR_PACKET_LENGTH  = 2'd2
   } csr_index_type;

   // Packet verdict codes
   typedef enum logic [1:0] {
      VERDICT_NEW       = 2'd0,
      VERDICT_DUPLICATE = 2'd1,
      VERDICT_INVALID   = 2'd2
   } verdict_type;

   // Pick the big-endian byte of a word at a header position
   function automatic logic [BYTE_W-1:0] word_byte(input logic [WORD_W-1:0] word,
                                                   input logic [1:0] pos);
      logic [BYTE_W-1:0] sel;
      case (pos)
         2'd0:    sel = word[31:24];
         2'd1:    sel = word[23:16];
         2'd2:    sel = word[15:8];
         default: sel = word[7:0];
      endcase
      return sel;
   endfunction

endpackage

### src/ppc_if.sv
// ----------------------------------------------------------------------------
// ppc_if
// Channel interfaces of the probe packet checker: byte input, verdict output
// and register write port.
// ----------------------------------------------------------------------------

// Byte stream into the checker
interface ppc_req_if import ppc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              last_byte;

   modport source (output valid, rx_byte, last_byte, input ready);
   modport sink   (input valid, rx_byte, last_byte, output ready);
endinterface

// Verdict words out of the checker
interface ppc_rsp_if import ppc_pkg::*;;
   logic              valid;
   logic              ready;
   verdict_type       verdict;
   logic [WORD_W-1:0] sequence_number;
   logic [WORD_W-1:0] valid_count;
   logic [WORD_W-1:0] duplicate_count;
   logic [WORD_W-1:0] invalid_count;

   modport source (output valid, verdict, sequence_number, valid_count,
                   duplicate_count, invalid_count, input ready);
   modport sink   (input valid, verdict, sequence_number, valid_count,
                   duplicate_count, invalid_count, output ready);
endinterface

// Register write port
interface ppc_csr_if import ppc_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [WORD_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/probe_packet_checker_unit.sv
// ----------------------------------------------------------------------------
// probe_packet_checker_unit
// Checks received probe packets one byte per cycle when not stalled and
// reports a verdict with running counters after the last byte of each packet.
// ----------------------------------------------------------------------------
// Takes one byte per clock at full rate when not stalled. Header and payload
// checks run on the byte as it is accepted; at the last byte the packet's
// sequence number addresses a 1024-entry received map (one block memory,
// registered read) in the verdict stage, and the verdict word then leaves
// through an output register. Apart from the clearing pass, the input stalls
// only while both the verdict stage and the output register are full and
// the output is not taken. After reset the received map is cleared by a pass
// over its MAX_SEQUENCES (1024) entries, one entry per cycle; no bytes are
// taken during that pass, while register writes are accepted at any time.

module probe_packet_checker_unit import ppc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ppc_req_if.sink   req_bus,
   ppc_rsp_if.source rsp_bus,
   ppc_csr_if.sink   csr_bus
);

   // Configuration registers
   logic [PHASE_W-1:0]  phase_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [LENGTH_W-1:0] length_ff;

   // Per-packet state
   logic [POS_W-1:0]  pos_ff,  pos_in;
   logic [WORD_W-1:0] hs_ff,   hs_in;
   logic [BYTE_W-1:0] pat_ff,  pat_in;
   logic              mm_ff,   mm_in;

   // Verdict stage
   logic              vs_valid_ff, vs_valid_in;
   logic              vs_ok_ff;
   logic [WORD_W-1:0] vs_seq_ff;
   logic              seen_rd_ff;

   // Output register and tallies
   logic              rsp_valid_ff, rsp_valid_in;
   verdict_type       rsp_verdict_ff;
   logic [WORD_W-1:0] rsp_seq_ff;
   logic [WORD_W-1:0] good_ff, good_in;
   logic [WORD_W-1:0] dup_ff,  dup_in;
   logic [WORD_W-1:0] bad_ff,  bad_in;

   // Map clearing pass
   logic                 clear_busy_ff;
   logic [SEQ_IDX_W-1:0] clear_idx_ff;

   // Received map
   logic                 seen_mem [MAX_SEQUENCES];
   logic                 wr_en;
   logic [SEQ_IDX_W-1:0] wr_addr;
   logic                 wr_data;
   logic [SEQ_IDX_W-1:0] rd_addr;

   logic              byte_fire, end_fire;
   logic              vs_move, rsp_load;
   logic [POS_W-1:0]  p;
   logic [BYTE_W-1:0] b;
   logic              pkt_ok;
   logic [WORD_W-1:0] pkt_seq;
   verdict_type       verdict;
   logic [WORD_W-1:0] tally_sum;

   // Handshakes
   assign vs_move       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !clear_busy_ff && (!vs_valid_ff || vs_move);
   assign byte_fire     = req_bus.valid && req_bus.ready;
   assign end_fire      = byte_fire && req_bus.last_byte;
   assign rsp_load      = vs_valid_ff && vs_move;
   assign csr_bus.ready = 1'b1;

   // Take register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_RESET;
         total_ff  <= TOTAL_RESET;
         length_ff <= LENGTH_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_EXPECTED_PHASE: phase_ff  <= csr_bus.data[PHASE_W-1:0];
            CSR_EXPECTED_TOTAL: total_ff  <= csr_bus.data[TOTAL_W-1:0];
            CSR_PACKET_LENGTH:  length_ff <= csr_bus.data[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Check the incoming byte against the header field or payload pattern
   always_comb begin
      p      = pos_ff;
      b      = req_bus.rx_byte;
      hs_in  = hs_ff;
      pat_in = pat_ff;
      mm_in  = mm_ff;
      if (p < POS_W'(PHASE_START)) begin
         if (b != word_byte(MARKER_WORD, p[1:0])) mm_in = 1'b1;
      end else if (p < POS_W'(SEQ_START)) begin
         if (b != word_byte(phase_ff, p[1:0])) mm_in = 1'b1;
      end else if (p < POS_W'(TOTAL_START)) begin
         hs_in = {hs_ff[WORD_W-BYTE_W-1:0], b};
         // seed the payload pattern once the sequence word is complete
         if (p == POS_W'(TOTAL_START - 1)) begin
            pat_in = hs_in[BYTE_W-1:0] + BYTE_W'(phase_ff[BYTE_W-1:0] * PHASE_WEIGHT)
                     + PATTERN_SEED;
         end
      end else if (p < POS_W'(HEADER_BYTES)) begin
         if (b != word_byte(WORD_W'(total_ff), p[1:0])) mm_in = 1'b1;
      end else if (p < POS_W'(MAX_PACKET_BYTES)) begin
         if (b != pat_ff) mm_in = 1'b1;
         pat_in = pat_ff + PATTERN_STEP;
      end

      // advance position, saturating one past the largest packet
      pos_in = (p <= POS_W'(MAX_PACKET_BYTES)) ? p + POS_W'(1) : p;

      // final checks at the last byte
      pkt_seq = (pos_in >= POS_W'(TOTAL_START)) ? hs_in : '0;
      pkt_ok  = !mm_in
                && (WORD_W'(pos_in) == WORD_W'(length_ff))
                && (pos_in >= POS_W'(HEADER_BYTES))
                && (pos_in <= POS_W'(MAX_PACKET_BYTES))
                && (hs_in < WORD_W'(total_ff))
                && (hs_in < WORD_W'(MAX_SEQUENCES));
   end

   // Hold per-packet state; restart at the last byte
   always_ff @(posedge clock) begin
      if (reset || end_fire) begin
         pos_ff <= '0;
         hs_ff  <= '0;
         pat_ff <= '0;
         mm_ff  <= 1'b0;
      end else if (byte_fire) begin
         pos_ff <= pos_in;
         hs_ff  <= hs_in;
         pat_ff <= pat_in;
         mm_ff  <= mm_in;
      end
   end

   // Verdict stage: hold the packet result while the map is read
   assign vs_valid_in = end_fire || (vs_valid_ff && !vs_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_valid_ff <= 1'b0;
      end else begin
         vs_valid_ff <= vs_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_fire) begin
         vs_ok_ff  <= pkt_ok;
         vs_seq_ff <= pkt_seq;
      end
   end

   // Classify and count
   always_comb begin
      good_in = good_ff;
      dup_in  = dup_ff;
      bad_in  = bad_ff;
      if (!vs_ok_ff) begin
         verdict = VERDICT_INVALID;
         bad_in  = bad_ff + WORD_W'(1);
      end else if (seen_rd_ff) begin
         verdict = VERDICT_DUPLICATE;
         dup_in  = dup_ff + WORD_W'(1);
      end else begin
         verdict = VERDICT_NEW;
         good_in = good_ff + WORD_W'(1);
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         good_ff      <= '0;
         dup_ff       <= '0;
         bad_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_load) begin
            good_ff <= good_in;
            dup_ff  <= dup_in;
            bad_ff  <= bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_verdict_ff <= verdict;
         rsp_seq_ff     <= vs_seq_ff;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.verdict         = rsp_verdict_ff;
   assign rsp_bus.sequence_number = rsp_seq_ff;
   assign rsp_bus.valid_count     = good_ff;
   assign rsp_bus.duplicate_count = dup_ff;
   assign rsp_bus.invalid_count   = bad_ff;

   // Sweep the received map to zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
      end else if (clear_busy_ff) begin
         clear_idx_ff <= clear_idx_ff + SEQ_IDX_W'(1);
         if (clear_idx_ff == SEQ_IDX_W'(MAX_SEQUENCES - 1)) clear_busy_ff <= 1'b0;
      end
   end

   // Received map: one write port, one registered read port
   assign wr_en   = clear_busy_ff || (rsp_load && verdict == VERDICT_NEW);
   assign wr_addr = clear_busy_ff ? clear_idx_ff : vs_seq_ff[SEQ_IDX_W-1:0];
   assign wr_data = !clear_busy_ff;
   assign rd_addr = hs_in[SEQ_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) seen_mem[wr_addr] <= wr_data;
   end

   // forward a same-cycle write so the read never sees stale data
   always_ff @(posedge clock) begin
      if (end_fire) begin
         seen_rd_ff <= (wr_en && wr_addr == rd_addr) ? wr_data : seen_mem[rd_addr];
      end
   end

   assign tally_sum = good_ff + dup_ff + bad_ff;

   // No bytes enter while the map is being cleared
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> !req_bus.ready)
      else $error("byte input open during map clearing");

   // Each verdict bumps exactly one tally
   a_one_tally_per_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> tally_sum == $past(tally_sum) + WORD_W'(1))
      else $error("tallies did not advance by one on a verdict");

   // Position saturates one past the largest packet
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_PACKET_BYTES + 1))
      else $error("byte position past saturation bound");

   // A stalled verdict stage keeps its packet
   a_vs_hold: assert property (@(posedge clock) disable iff (reset)
      (vs_valid_ff && !vs_move) |=> (vs_valid_ff && $stable(vs_seq_ff) && $stable(vs_ok_ff)))
      else $error("verdict stage lost its packet while stalled");

endmodule
